### hw/rtl/tme_pkg.sv
// ----------------------------------------------------------------------------
// tme_pkg
// Types, opcodes and controller/datapath signal groups shared across the
// tape machine executor.
// ----------------------------------------------------------------------------
package tme_pkg;

    // instruction kinds
    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_MVR    = 4'd2;
    localparam logic [3:0] OP_LEFT   = 4'd3;
    localparam logic [3:0] OP_OUT    = 4'd4;
    localparam logic [3:0] OP_IN     = 4'd5;
    localparam logic [3:0] OP_JZ     = 4'd6;
    localparam logic [3:0] OP_JNZ    = 4'd7;
    localparam logic [3:0] OP_CLR    = 4'd8;
    localparam logic [3:0] OP_MOVE   = 4'd9;
    localparam logic [3:0] OP_DIST   = 4'd10;
    localparam logic [3:0] OP_SCANR  = 4'd11;
    localparam logic [3:0] OP_SCANL  = 4'd12;
    localparam logic [3:0] OP_SET    = 4'd13;
    localparam logic [3:0] OP_PAIR   = 4'd14;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [14:0]        instr_index;
        logic signed [15:0] arg_first;
        logic signed [15:0] arg_second;
        logic signed [15:0] arg_third;
        logic signed [15:0] arg_fourth;
        logic [7:0]         in_byte_first;
        logic [7:0]         in_byte_second;
    } in_item_t;

    typedef struct packed {
        logic [14:0] next_index;
        logic        jump_taken;
        logic [1:0]  out_count;
        logic [7:0]  out_byte_first;
        logic [7:0]  out_byte_second;
        logic [14:0] cell_pointer;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic clear_we;
        logic load_item;
        logic load_cell;
        logic exec;
        logic tgt_read;
        logic tgt_write;
        logic tgt_next;
        logic zero_write;
        logic mod_start;
        logic mod_step;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic op_move;
        logic op_scan;
        logic pair_first;
        logic cell_zero;
        logic scan_go;
        logic tgt_in_range;
        logic tgt_more;
        logic mod_last;
        logic out_busy;
    } status_t;

    // codes that act as a simple cell or pointer operation
    function automatic logic is_simple(input logic [3:0] code);
        is_simple = (code == OP_ADD) || (code == OP_SUB) || (code == OP_MVR) ||
                    (code == OP_LEFT) || (code == OP_OUT) || (code == OP_IN) ||
                    (code == OP_CLR) || (code == OP_SET);
    endfunction

endpackage

### hw/rtl/tape_machine_executor.sv
// ----------------------------------------------------------------------------
// tape_machine_executor
// Executes one optimized tape-machine instruction per input beat against a
// byte tape and a cell pointer, returning one result beat per instruction.
// ----------------------------------------------------------------------------
// After reset the block sweeps the tape to zero, one cell per cycle, before
// the first beat is accepted. Items are then handled one at a time by a
// sequencer around a single tape RAM with registered read: a plain
// instruction goes from accept through fetch, load, execute, the next-index
// modulo unit (operand load, reciprocal multiply, multiply back, subtract and
// one correcting compare) and handoff, and the next beat can be accepted in
// the cycle after the handoff. A fused pair repeats fetch, load and execute,
// move-add and distribute add a current-cell clear plus a target read and
// write for each in-range target and a read alone for each target off the
// tape, and a scan repeats fetch, load and execute per nonzero cell walked
// over. The result sits in an output register, so the next beat is taken
// while an earlier result waits on m_ready.
module tape_machine_executor #(
    parameter int TAPE_CELLS    = 32768,
    parameter int PROGRAM_WORDS = 32768
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tme_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output tme_pkg::out_item_t  m_item
);

    import tme_pkg::*;

    cmd_t    cmd;
    status_t st;

    tme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    tme_datapath #(
        .TAPE_CELLS    (TAPE_CELLS),
        .PROGRAM_WORDS (PROGRAM_WORDS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .st      (st),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

### hw/rtl/tme_ram.sv
// ----------------------------------------------------------------------------
// tme_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/tme_datapath.sv
// ----------------------------------------------------------------------------
// tme_datapath
// Tape memory, cell pointer, per-item working registers, index modulo unit
// and the result register.
// ----------------------------------------------------------------------------
module tme_datapath #(
    parameter int TAPE_CELLS    = 32768,
    parameter int PROGRAM_WORDS = 32768
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tme_pkg::in_item_t   s_item,
    input  tme_pkg::cmd_t       cmd,
    output tme_pkg::status_t    st,
    output logic                m_valid,
    input  logic                m_ready,
    output tme_pkg::out_item_t  m_item
);

    import tme_pkg::*;

    localparam int PTR_W = $clog2(TAPE_CELLS);
    localparam int SW    = ((PTR_W > 16) ? PTR_W : 16) + 2;

    localparam logic [PTR_W-1:0]    PTR_LAST = PTR_W'(TAPE_CELLS - 1);
    localparam logic signed [SW-1:0] TC_S    = SW'(TAPE_CELLS);
    localparam logic signed [SW-1:0] TC_M1_S = SW'(TAPE_CELLS - 1);
    localparam logic signed [SW-1:0] TC_M3_S = SW'(TAPE_CELLS - 3);
    localparam logic [16:0]          PW_C    = 17'(PROGRAM_WORDS);
    localparam logic [12:0]          RCP_C   = 13'(65536 / PROGRAM_WORDS);

    // registers
    in_item_t         item_reg;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [PTR_W-1:0] clr_reg;
    logic [7:0]       cell_reg;
    logic             phase_reg;
    logic             sel_reg;
    logic             taken_reg;
    logic [1:0]       in_used_reg, in_used_next;
    logic [1:0]       out_used_reg, out_used_next;
    logic [7:0]       out_first_reg, out_first_next;
    logic [7:0]       out_second_reg, out_second_next;
    logic [15:0]      div_reg;
    logic [12:0]      quo_reg;
    logic [16:0]      qp_reg;
    logic [16:0]      rem_reg;
    logic [1:0]       cnt_reg;
    logic             m_valid_reg;
    out_item_t        m_item_reg;

    // tape port
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic [PTR_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    // execute logic
    logic                 pair_op;
    logic [15:0]          sub_full;
    logic [15:0]          sub_arg;
    logic [3:0]           sub_code;
    logic                 sub_act;
    logic [7:0]           cell_new;
    logic signed [SW-1:0] ptr_s;
    logic signed [SW-1:0] np;
    logic signed [SW-1:0] tgt_s;
    logic [PTR_W-1:0]     tgt_addr;
    logic [7:0]           tgt_mul;
    logic [7:0]           tgt_sum;
    logic                 cell_nz;

    // modulo products
    logic [28:0] quo_full;
    logic [29:0] qp_full;

    tme_ram #(
        .WIDTH (8),
        .DEPTH (TAPE_CELLS)
    ) u_tape (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pair_op  = (item_reg.opcode == OP_PAIR);
    assign sub_full = pair_op ? (phase_reg ? item_reg.arg_second : item_reg.arg_first)
                              : {12'd0, item_reg.opcode};
    assign sub_arg  = pair_op ? (phase_reg ? item_reg.arg_fourth : item_reg.arg_third)
                              : item_reg.arg_first;
    assign sub_code = sub_full[3:0];
    assign sub_act  = (sub_full[15:4] == 12'd0) && is_simple(sub_code);
    assign ptr_s    = signed'(SW'(ptr_reg));
    assign cell_nz  = (cell_reg != 8'd0);

    // simple op effect on cell, pointer and io bookkeeping
    always_comb begin
        cell_new        = cell_reg;
        ptr_next        = ptr_reg;
        in_used_next    = in_used_reg;
        out_used_next   = out_used_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        np              = ptr_s;
        if (sub_act) begin
            unique case (sub_code)
                OP_ADD:   cell_new = cell_reg + sub_arg[7:0];
                OP_SUB:   cell_new = cell_reg - sub_arg[7:0];
                OP_MVR: begin
                    np = ptr_s + SW'(signed'(sub_arg));
                    if (np >= TC_M3_S) begin
                        np = TC_M3_S;
                    end else if (np < 0) begin
                        np = '0;
                    end
                    ptr_next = np[PTR_W-1:0];
                end
                OP_LEFT: begin
                    np = ptr_s - SW'(signed'(sub_arg));
                    if (np < 0) begin
                        np = '0;
                    end else if (np > TC_M1_S) begin
                        np = TC_M1_S;
                    end
                    ptr_next = np[PTR_W-1:0];
                end
                OP_OUT: begin
                    if (out_used_reg == 2'd0) begin
                        out_first_next = cell_reg;
                        out_used_next  = 2'd1;
                    end else if (out_used_reg == 2'd1) begin
                        out_second_next = cell_reg;
                        out_used_next   = 2'd2;
                    end
                end
                OP_IN: begin
                    if (in_used_reg == 2'd0) begin
                        cell_new     = item_reg.in_byte_first;
                        in_used_next = 2'd1;
                    end else if (in_used_reg == 2'd1) begin
                        cell_new     = item_reg.in_byte_second;
                        in_used_next = 2'd2;
                    end
                end
                OP_CLR:   cell_new = 8'd0;
                OP_SET:   cell_new = sub_arg[7:0];
                default:  cell_new = cell_reg;
            endcase
        end
    end

    // move-add / distribute target
    assign tgt_s    = ptr_s + SW'(signed'(sel_reg ? item_reg.arg_third : item_reg.arg_first));
    assign tgt_addr = tgt_s[PTR_W-1:0];
    assign tgt_mul  = sel_reg ? item_reg.arg_fourth[7:0] : item_reg.arg_second[7:0];
    assign tgt_sum  = ram_rdata + 8'(cell_reg * tgt_mul);

    // reciprocal estimate of the quotient is low by at most one, so one
    // compare and subtract finishes the remainder
    assign quo_full = div_reg * RCP_C;
    assign qp_full  = quo_reg * PW_C;

    // tape port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = cell_new;
        ram_raddr = cmd.tgt_read ? tgt_addr : ptr_reg;
        if (cmd.clear_we) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = 8'd0;
        end else if (cmd.exec && sub_act) begin
            ram_we = 1'b1;
        end else if (cmd.tgt_write) begin
            ram_we    = 1'b1;
            ram_waddr = tgt_addr;
            ram_wdata = tgt_sum;
        end else if (cmd.zero_write) begin
            ram_we    = 1'b1;
            ram_wdata = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            clr_reg     <= '0;
            phase_reg   <= 1'b0;
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_we) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.load_item) begin
                phase_reg <= 1'b0;
                sel_reg   <= 1'b0;
            end
            if (cmd.exec) begin
                if (pair_op) begin
                    phase_reg <= 1'b1;
                end
                if (st.scan_go) begin
                    ptr_reg <= (item_reg.opcode == OP_SCANR) ? ptr_reg + 1'b1
                                                               : ptr_reg - 1'b1;
                end else begin
                    ptr_reg <= ptr_next;
                end
            end
            if (cmd.tgt_next) begin
                sel_reg <= 1'b1;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg       <= s_item;
            taken_reg      <= 1'b0;
            in_used_reg    <= 2'd0;
            out_used_reg   <= 2'd0;
            out_first_reg  <= 8'd0;
            out_second_reg <= 8'd0;
        end
        if (cmd.load_cell) begin
            cell_reg <= ram_rdata;
        end
        if (cmd.exec) begin
            in_used_reg    <= in_used_next;
            out_used_reg   <= out_used_next;
            out_first_reg  <= out_first_next;
            out_second_reg <= out_second_next;
            if (item_reg.opcode == OP_JZ) begin
                taken_reg <= !cell_nz;
            end else if (item_reg.opcode == OP_JNZ) begin
                taken_reg <= cell_nz;
            end
        end
        if (cmd.mod_start) begin
            div_reg <= taken_reg ? item_reg.arg_first : 16'(item_reg.instr_index) + 16'd1;
            cnt_reg <= 2'd0;
        end else if (cmd.mod_step) begin
            cnt_reg <= cnt_reg + 2'd1;
            // quotient estimate, multiply back, subtract, correct
            unique case (cnt_reg)
                2'd0:    quo_reg <= quo_full[28:16];
                2'd1:    qp_reg  <= qp_full[16:0];
                2'd2:    rem_reg <= {1'b0, div_reg} - qp_reg;
                default: rem_reg <= (rem_reg >= PW_C) ? rem_reg - PW_C : rem_reg;
            endcase
        end
        if (cmd.load_out) begin
            m_item_reg.next_index      <= rem_reg[14:0];
            m_item_reg.jump_taken      <= taken_reg;
            m_item_reg.out_count       <= out_used_reg;
            m_item_reg.out_byte_first  <= out_first_reg;
            m_item_reg.out_byte_second <= out_second_reg;
            m_item_reg.cell_pointer    <= 15'(ptr_reg);
        end
    end

    assign st.clear_last   = (clr_reg == PTR_LAST);
    assign st.op_move      = (item_reg.opcode == OP_MOVE) || (item_reg.opcode == OP_DIST);
    assign st.op_scan      = (item_reg.opcode == OP_SCANR) || (item_reg.opcode == OP_SCANL);
    assign st.pair_first   = pair_op && !phase_reg;
    assign st.cell_zero    = !cell_nz;
    assign st.scan_go      = cell_nz &&
                             (((item_reg.opcode == OP_SCANR) && (ptr_reg != PTR_LAST)) ||
                              ((item_reg.opcode == OP_SCANL) && (ptr_reg != '0)));
    assign st.tgt_in_range = (tgt_s >= 0) && (tgt_s < TC_S);
    assign st.tgt_more     = (item_reg.opcode == OP_DIST) && !sel_reg;
    assign st.mod_last     = (cnt_reg == 2'd3);
    assign st.out_busy     = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### hw/rtl/tme_ctrl.sv
// ----------------------------------------------------------------------------
// tme_ctrl
// Sequencer for the tape machine executor: clearing pass, item fetch,
// execute, target read-modify-writes, index modulo and result handoff.
// ----------------------------------------------------------------------------
module tme_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tme_pkg::status_t  st,
    output tme_pkg::cmd_t     cmd
);

    import tme_pkg::*;

    typedef enum logic [10:0] {
        ST_CLEAR   = 11'b000_0000_0001,
        ST_IDLE    = 11'b000_0000_0010,
        ST_FETCH   = 11'b000_0000_0100,
        ST_LOAD    = 11'b000_0000_1000,
        ST_EXEC    = 11'b000_0001_0000,
        ST_TREAD   = 11'b000_0010_0000,
        ST_TLOAD   = 11'b000_0100_0000,
        ST_ZERO    = 11'b000_1000_0000,
        ST_MODINIT = 11'b001_0000_0000,
        ST_MOD     = 11'b010_0000_0000,
        ST_RESULT  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_we = 1'b1;
                if (st.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // tape read of the current cell is in flight
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load_cell = 1'b1;
                state_next    = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                priority if (st.op_move) begin
                    state_next = st.cell_zero ? ST_ZERO : ST_TREAD;
                end else if (st.op_scan) begin
                    state_next = st.scan_go ? ST_FETCH : ST_MODINIT;
                end else if (st.pair_first) begin
                    // second sub-op works on the refreshed current cell
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_MODINIT;
                end
            end
            ST_TREAD: begin
                cmd.tgt_read = 1'b1;
                priority if (st.tgt_in_range) begin
                    state_next = ST_TLOAD;
                end else if (st.tgt_more) begin
                    cmd.tgt_next = 1'b1;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_TLOAD: begin
                cmd.tgt_write = 1'b1;
                if (st.tgt_more) begin
                    cmd.tgt_next = 1'b1;
                    state_next   = ST_TREAD;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                cmd.zero_write = 1'b1;
                state_next     = ST_MODINIT;
            end
            ST_MODINIT: begin
                cmd.mod_start = 1'b1;
                state_next    = ST_MOD;
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (st.mod_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!st.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### bench/tape_machine_executor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_machine_executor_checker
// Watches both channels of the tape machine executor. Every accepted
// instruction beat runs through a private copy of the tape and the pointer,
// and every result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tape_machine_executor_checker #(
    parameter int TAPE_CELLS    = 32768,
    parameter int PROGRAM_WORDS = 32768
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  tme_pkg::in_item_t  s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  tme_pkg::out_item_t m_item,
    output int                 fail_count,
    output int                 pending_count
);

    import tme_pkg::*;

    logic [7:0] tape_mem [TAPE_CELLS];
    int         cell_ptr;
    logic [7:0] in_bytes  [2];
    int         in_taken;
    logic [7:0] out_bytes [2];
    int         out_made;
    out_item_t  expected_results [$];
    int         mismatches = 0;
    int         waiting = 0;

    assign fail_count    = mismatches;
    assign pending_count = waiting;

    // one plain cell or pointer op; codes outside the plain set do nothing
    task automatic apply_simple(input logic signed [15:0] code,
                                input logic signed [15:0] arg);
        int np;
        if (code >= 0 && code <= 15) begin
            case (code[3:0])
                OP_ADD:   tape_mem[cell_ptr] = tape_mem[cell_ptr] + arg[7:0];
                OP_SUB:   tape_mem[cell_ptr] = tape_mem[cell_ptr] - arg[7:0];
                OP_MVR: begin
                    np = cell_ptr + int'(arg);
                    if (np >= TAPE_CELLS - 3) np = TAPE_CELLS - 3;
                    if (np < 0) np = 0;
                    cell_ptr = np;
                end
                OP_LEFT: begin
                    np = cell_ptr - int'(arg);
                    if (np < 0) np = 0;
                    if (np > TAPE_CELLS - 1) np = TAPE_CELLS - 1;
                    cell_ptr = np;
                end
                OP_OUT: begin
                    if (out_made < 2) begin
                        out_bytes[out_made] = tape_mem[cell_ptr];
                        out_made++;
                    end
                end
                OP_IN: begin
                    if (in_taken < 2) begin
                        tape_mem[cell_ptr] = in_bytes[in_taken];
                        in_taken++;
                    end
                end
                OP_CLR:   tape_mem[cell_ptr] = 8'h00;
                OP_SET:   tape_mem[cell_ptr] = arg[7:0];
                default: ;
            endcase
        end
    endtask

    // targets off either end of the tape are dropped
    task automatic add_scaled(input int target, input logic [7:0] val,
                              input logic [7:0] mul);
        if (target >= 0 && target < TAPE_CELLS)
            tape_mem[target] = tape_mem[target] + val * mul;
    endtask

    task automatic execute_instruction(input in_item_t ins, output out_item_t res);
        int         nxt;
        int         target;
        logic [7:0] val;
        logic       taken;
        nxt          = (int'(ins.instr_index) + 1) % PROGRAM_WORDS;
        target       = int'(ins.arg_first[15:0]) % PROGRAM_WORDS;
        taken        = 1'b0;
        in_bytes[0]  = ins.in_byte_first;
        in_bytes[1]  = ins.in_byte_second;
        in_taken     = 0;
        out_bytes[0] = 8'h00;
        out_bytes[1] = 8'h00;
        out_made     = 0;
        val          = tape_mem[cell_ptr];
        case (ins.opcode)
            OP_ADD, OP_SUB, OP_MVR, OP_LEFT, OP_OUT, OP_IN, OP_CLR, OP_SET:
                apply_simple(16'(ins.opcode), ins.arg_first);
            OP_JZ: begin
                if (val == 8'h00) begin
                    nxt   = target;
                    taken = 1'b1;
                end
            end
            OP_JNZ: begin
                if (val != 8'h00) begin
                    nxt   = target;
                    taken = 1'b1;
                end
            end
            OP_MOVE: begin
                if (val != 8'h00)
                    add_scaled(cell_ptr + int'(ins.arg_first), val, ins.arg_second[7:0]);
                tape_mem[cell_ptr] = 8'h00;
            end
            OP_DIST: begin
                if (val != 8'h00) begin
                    add_scaled(cell_ptr + int'(ins.arg_first), val, ins.arg_second[7:0]);
                    add_scaled(cell_ptr + int'(ins.arg_third), val, ins.arg_fourth[7:0]);
                end
                tape_mem[cell_ptr] = 8'h00;
            end
            OP_SCANR: begin
                while (cell_ptr < TAPE_CELLS - 1 && tape_mem[cell_ptr] != 8'h00)
                    cell_ptr++;
            end
            OP_SCANL: begin
                while (cell_ptr > 0 && tape_mem[cell_ptr] != 8'h00)
                    cell_ptr--;
            end
            OP_PAIR: begin
                apply_simple(ins.arg_first, ins.arg_third);
                apply_simple(ins.arg_second, ins.arg_fourth);
            end
            default: ;
        endcase
        res.next_index      = 15'(nxt);
        res.jump_taken      = taken;
        res.out_count       = 2'(out_made);
        res.out_byte_first  = out_bytes[0];
        res.out_byte_second = out_bytes[1];
        res.cell_pointer    = 15'(cell_ptr);
    endtask

    always @(posedge aclk) begin : watch
        out_item_t want;
        out_item_t got;
        if (!aresetn) begin
            for (int i = 0; i < TAPE_CELLS; i++) tape_mem[i] = 8'h00;
            cell_ptr = 0;
            expected_results.delete();
        end else begin
            // results first: a result never belongs to a beat taken at the same edge
            if (m_valid && m_ready) begin
                got = m_item;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing expected: next %0d ptr %0d",
                                 $realtime, got.next_index, got.cell_pointer);
                end else begin
                    want = expected_results.pop_front();
                    if (got.next_index !== want.next_index ||
                        got.jump_taken !== want.jump_taken ||
                        got.out_count !== want.out_count ||
                        got.out_byte_first !== want.out_byte_first ||
                        got.out_byte_second !== want.out_byte_second ||
                        got.cell_pointer !== want.cell_pointer) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch (expected / actual)", $realtime);
                            $display("  next %0d / %0d  jump %0b / %0b  count %0d / %0d",
                                     want.next_index, got.next_index, want.jump_taken,
                                     got.jump_taken, want.out_count, got.out_count);
                            $display("  bytes %02h %02h / %02h %02h  ptr %0d / %0d",
                                     want.out_byte_first, want.out_byte_second,
                                     got.out_byte_first, got.out_byte_second,
                                     want.cell_pointer, got.cell_pointer);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                execute_instruction(s_item, want);
                expected_results.push_back(want);
            end
        end
        waiting = expected_results.size();
    end

endmodule

### bench/tape_machine_executor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_machine_executor_tb
// Drives instruction beats into the tape machine executor: a directed opening
// over field extremes, clamps, skipped targets and scan ends, then random
// instructions mixed with fill-and-scan sequences under several idle and
// stall patterns, including one long receiver hold-off. Checking is done by
// the checker module instantiated beside the block.
// ----------------------------------------------------------------------------
module tape_machine_executor_tb;
    import tme_pkg::*;

    localparam int TAPE_CELLS       = 32768;
    localparam int PROGRAM_WORDS    = 32768;
    localparam int RANDOM_PER_PHASE = 250;
    localparam int HOLD_OFF_CYCLES  = 400;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;
    int        fail_count;
    int        pending_count;

    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    logic      hold_off       = 1'b0;
    int        items_sent     = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    tape_machine_executor #(
        .TAPE_CELLS   (TAPE_CELLS),
        .PROGRAM_WORDS(PROGRAM_WORDS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    tape_machine_executor_checker #(
        .TAPE_CELLS   (TAPE_CELLS),
        .PROGRAM_WORDS(PROGRAM_WORDS)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always @(negedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // mostly small values so the pointer stays local and cells pile up
    function automatic logic signed [15:0] operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'(int'($urandom_range(0, 12)) - 4);
        if (r < 90) return 16'($urandom);
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'shffff;
            default: return 16'sh0100;
        endcase
    endfunction

    function automatic logic signed [15:0] sub_code();
        if ($urandom_range(0, 99) < 20) return 16'($urandom);
        case ($urandom_range(0, 7))
            0: return 16'(OP_ADD);
            1: return 16'(OP_SUB);
            2: return 16'(OP_MVR);
            3: return 16'(OP_LEFT);
            4: return 16'(OP_OUT);
            5: return 16'(OP_IN);
            6: return 16'(OP_CLR);
            default: return 16'(OP_SET);
        endcase
    endfunction

    function automatic in_item_t mk(input logic [3:0] op, input int a1, input int a2,
                                    input int a3, input int a4, input int b1, input int b2);
        in_item_t it;
        it.opcode         = op;
        it.instr_index    = 15'($urandom);
        it.arg_first      = 16'(a1);
        it.arg_second     = 16'(a2);
        it.arg_third      = 16'(a3);
        it.arg_fourth     = 16'(a4);
        it.in_byte_first  = 8'(b1);
        it.in_byte_second = 8'(b2);
        return it;
    endfunction

    function automatic in_item_t random_instruction();
        in_item_t it;
        it.opcode         = 4'($urandom_range(0, 15));
        it.instr_index    = 15'($urandom);
        it.arg_first      = operand();
        it.arg_second     = operand();
        it.arg_third      = operand();
        it.arg_fourth     = operand();
        it.in_byte_first  = 8'($urandom);
        it.in_byte_second = 8'($urandom);
        if (it.opcode == OP_PAIR) begin
            it.arg_first  = sub_code();
            it.arg_second = sub_code();
        end
        return it;
    endfunction

    // entered just after a falling edge, returns just after a falling edge
    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // a run of nonzero cells, then a scan over it in either direction and maybe a spread
    task automatic send_fill_and_scan();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) begin
            send_item(mk(OP_SET, $urandom_range(1, 255), 0, 0, 0, 0, 0));
            send_item(mk(OP_MVR, 1, 0, 0, 0, 0, 0));
        end
        send_item(mk(OP_LEFT, $urandom_range(1, 2), 0, 0, 0, 0, 0));
        send_item(mk($urandom_range(0, 1) ? OP_SCANL : OP_SCANR, 0, 0, 0, 0, 0, 0));
        if ($urandom_range(0, 1)) begin
            send_item(mk(OP_LEFT, 1, 0, 0, 0, 0, 0));
            send_item(mk(OP_DIST, int'($urandom_range(0, 6)) - 3, $urandom,
                         int'($urandom_range(0, 6)) - 3, $urandom, 0, 0));
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold);
        int goal;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal           = items_sent + RANDOM_PER_PHASE;
        if (with_hold) begin
            fork
                begin
                    hold_off = 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                    hold_off = 1'b0;
                end
            join_none
        end
        while (items_sent < goal) begin
            if ($urandom_range(0, 99) < 15) send_fill_and_scan();
            else send_item(random_instruction());
        end
    endtask

    initial begin : stimulus
        in_item_t it;
        int       guard;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        it = mk(OP_OUT, 0, 0, 0, 0, 0, 0);
        it.instr_index = 15'd0;
        send_item(it);
        it = mk(OP_ADD, 32767, 0, 0, 0, 0, 0);
        it.instr_index = 15'h7fff;
        send_item(it);
        send_item(mk(OP_SUB, -32768, 0, 0, 0, 0, 0));
        send_item(mk(OP_SET, 'h1234, 0, 0, 0, 0, 0));
        send_item(mk(OP_IN, 0, 0, 0, 0, 255, 0));
        send_item(mk(OP_JZ, -1, 0, 0, 0, 0, 0));
        send_item(mk(OP_JNZ, -1, 0, 0, 0, 0, 0));
        send_item(mk(OP_PAIR, int'(OP_OUT), int'(OP_OUT), 0, 0, 0, 0));
        send_item(mk(OP_PAIR, int'(OP_IN), int'(OP_IN), 0, 0, 0, 170));
        // sub-op codes outside the plain set are no-ops
        send_item(mk(OP_PAIR, -1, int'(OP_JZ), 5, 5, 0, 0));
        send_item(mk(OP_MOVE, 1, 3, 0, 0, 0, 0));
        send_item(mk(OP_SET, 5, 0, 0, 0, 0, 0));
        // first target falls off the low end of the tape
        send_item(mk(OP_DIST, -1, 2, 2, -1, 0, 0));
        send_item(mk(OP_JZ, 300, 0, 0, 0, 0, 0));
        send_item(mk(OP_MVR, 32767, 0, 0, 0, 0, 0));
        send_item(mk(OP_MVR, -32768, 0, 0, 0, 0, 0));
        send_item(mk(OP_LEFT, -32768, 0, 0, 0, 0, 0));
        send_item(mk(OP_SET, 7, 0, 0, 0, 0, 0));
        // first target falls off the high end
        send_item(mk(OP_DIST, 1, 1, -2, 255, 0, 0));
        send_item(mk(OP_SCANR, 0, 0, 0, 0, 0, 0));
        send_item(mk(OP_SCANL, 0, 0, 0, 0, 0, 0));
        send_item(mk(OP_LEFT, 32767, 0, 0, 0, 0, 0));
        send_item(mk(OP_SET, 1, 0, 0, 0, 0, 0));
        send_item(mk(OP_SCANL, 0, 0, 0, 0, 0, 0));
        send_item(mk(OP_SCANR, 0, 0, 0, 0, 0, 0));
        send_item(mk(4'hf, -1, -1, -1, -1, 255, 255));
        send_item(mk(OP_MOVE, -5, 1, 0, 0, 0, 0));

        run_phase(0, 0, 1'b1);
        run_phase(74, 0, 1'b0);
        run_phase(0, 74, 1'b0);
        run_phase(12, 12, 1'b0);
        s_valid <= 1'b0;

        guard = 0;
        while (pending_count != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
